>>> design/hbc_pkg.sv
// Package for the Hamming(7,4) byte codec: operation codes, bit positions and nibble functions.
package hbc_pkg;

  // Operation select carried with each input beat
  typedef enum logic {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // Coded byte layout: parity at 7, 6, 4; data at 5, 3, 2, 1; bit 0 unused
  localparam int unsigned PA_POS = 7;
  localparam int unsigned PB_POS = 6;
  localparam int unsigned D3_POS = 5;
  localparam int unsigned PC_POS = 4;
  localparam int unsigned D2_POS = 3;
  localparam int unsigned D1_POS = 2;
  localparam int unsigned D0_POS = 1;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nibble_t;
  typedef logic [2:0] syndrome_t;

  // Place a nibble into a coded byte and add its three parity bits
  function automatic byte_t encode_nibble(input nibble_t nib);
    byte_t c;
    c         = '0;
    c[D3_POS] = nib[3];
    c[D2_POS] = nib[2];
    c[D1_POS] = nib[1];
    c[D0_POS] = nib[0];
    c[PA_POS] = nib[0] ^ nib[2] ^ nib[3];
    c[PB_POS] = nib[0] ^ nib[1] ^ nib[3];
    c[PC_POS] = nib[0] ^ nib[1] ^ nib[2];
    return c;
  endfunction

  // Bit that a syndrome points at; zero syndrome means no correction
  function automatic byte_t syndrome_flip(input syndrome_t syn);
    byte_t flip;
    flip = '0;
    unique case (syn)
      3'd7: flip[D0_POS] = 1'b1;
      3'd6: flip[D3_POS] = 1'b1;
      3'd5: flip[D2_POS] = 1'b1;
      3'd4: flip[PA_POS] = 1'b1;
      3'd3: flip[D1_POS] = 1'b1;
      3'd2: flip[PB_POS] = 1'b1;
      3'd1: flip[PC_POS] = 1'b1;
      3'd0: flip = '0;
    endcase
    return flip;
  endfunction

  // Check a coded byte, fix the bit the syndrome names, pull out the nibble
  function automatic nibble_t decode_nibble(input byte_t c);
    syndrome_t syn;
    byte_t     fixed;
    syn[2] = c[PA_POS] ^ c[D0_POS] ^ c[D2_POS] ^ c[D3_POS];
    syn[1] = c[PB_POS] ^ c[D0_POS] ^ c[D1_POS] ^ c[D3_POS];
    syn[0] = c[PC_POS] ^ c[D0_POS] ^ c[D1_POS] ^ c[D2_POS];
    fixed  = c ^ syndrome_flip(syn);
    return {fixed[D3_POS], fixed[D2_POS], fixed[D1_POS], fixed[D0_POS]};
  endfunction

endpackage

>>> design/hamming_byte_codec.sv
// Top level of the Hamming(7,4) single-error-correcting byte codec.

// A beat is taken on every clock edge where start is high; busy is always
// low, so one beat per cycle is sustained. Each beat gives exactly one result,
// registered first in the input register and then in the result register,
// with the parity and syndrome XOR logic between the two registers. The result
// shows on the out_ ports for one cycle with out_valid high and must be
// captured then, as the receiver has no way to stall it. Encode (in_func 0)
// returns out_code_high and out_code_low with out_decoded_byte zero; decode
// (in_func 1) corrects one bit error per coded byte and returns
// out_decoded_byte with both code outputs zero. Double errors are not flagged.
module hamming_byte_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  hbc_pkg::byte_t      in_data_byte,
  input  hbc_pkg::byte_t      in_coded_first,
  input  hbc_pkg::byte_t      in_coded_second,
  output logic                out_valid,
  output hbc_pkg::byte_t      out_decoded_byte,
  output hbc_pkg::byte_t      out_code_high,
  output hbc_pkg::byte_t      out_code_low
);
  import hbc_pkg::*;

  // Input stage
  logic  in_valid_r;
  func_t func_r;
  byte_t data_r;
  byte_t first_r;
  byte_t second_r;

  // Result stage
  logic  out_valid_r;
  byte_t decoded_r, decoded_nxt;
  byte_t high_r, high_nxt;
  byte_t low_r, low_nxt;

  // Never stalls: a beat can enter every cycle
  assign busy = 1'b0;

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r   <= func_t'(in_func);
      data_r   <= in_data_byte;
      first_r  <= in_coded_first;
      second_r <= in_coded_second;
    end
  end

  // Encode or decode the registered beat
  always_comb begin
    decoded_nxt = '0;
    high_nxt    = '0;
    low_nxt     = '0;
    unique case (func_r)
      FUNC_ENCODE: begin
        high_nxt = encode_nibble(data_r[7:4]);
        low_nxt  = encode_nibble(data_r[3:0]);
      end
      FUNC_DECODE: begin
        decoded_nxt = {decode_nibble(first_r), decode_nibble(second_r)};
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      decoded_r <= decoded_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_decoded_byte = decoded_r;
  assign out_code_high    = high_r;
  assign out_code_low     = low_r;

  // Checks
  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_valid_r)
    else $error("accepted beat did not reach the input stage");

  a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_valid)
    else $error("staged beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |=> !out_valid)
    else $error("result strobe without a staged beat");

  a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_decoded_byte == '0) ||
                  (out_code_high == '0 && out_code_low == '0))
    else $error("encode and decode outputs both nonzero");

  a_bit0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_code_high[0] && !out_code_low[0])
    else $error("coded byte has bit zero set");

endmodule
